### src/shash_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the SHA-256 stream hasher.
package shash_pkg;

   typedef logic [31:0]       word_type;
   typedef logic [15:0][31:0] block_type;
   typedef logic [7:0][31:0]  digest_type;

   // Control from the message sequencer to the compression core.
   typedef struct packed {
      logic start;  // compress the presented block, core must be idle
      logic init;   // load the initial hash values into the chain
   } core_ctl_type;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam logic [3:0]  LEN_HI_WORD = 4'd14;
   localparam logic [3:0]  LEN_LO_WORD = 4'd15;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [5:0]  LAST_ROUND  = 6'd63;
   localparam logic [2:0]  LAST_INDEX  = 3'd7;

   localparam digest_type INITIAL_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic word_type rotr(input word_type v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

   function automatic word_type round_k(input logic [5:0] r);
      word_type k;
      case (r)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

### src/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// Top level of the SHA-256 stream hasher: byte packing, padding and digest output.
//
// The hasher takes a message one byte per transaction and returns its SHA-256
// digest as eight 32-bit transactions, word 0 (most significant) first, with
// last_word set on word 7. A transaction with end_of_message set closes the
// message; if it also carries a byte, that byte is the last of the message, and
// a lone end_of_message with no byte hashes the empty message. A transaction
// with neither a byte nor the mark is taken and has no effect. Bytes are taken
// one per clock until a 64-byte block fills; the block then goes to a single
// shared compression core that runs one round per clock, and while the core
// launches, runs its rounds, adds into the chain and hands the result back,
// req_stall is high. At the end of a message the padding byte is written in
// its own state, then one or two further blocks are compressed (two when 56
// or more bytes sit in the last block), and the eight digest words follow,
// one per clock as the receiver allows. The bit length wraps modulo 2^64.
// After the last digest word the hasher starts a new message from the
// initial hash values.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {T_IDLE, T_PAD, T_LAUNCH, T_WAIT, T_OUT} state_type;

   state_type   state_ff;
   logic [63:0] count_ff;     // bytes taken in this message
   logic [4:0]  fill_ff;      // words of the block buffer that hold live data
   logic        eom_ff;       // the message has ended
   logic        pad_ff;       // the padding byte has been written
   logic        len_ff;       // the block in flight carries the bit length
   logic [2:0]  index_ff;     // digest word being presented

   shash_pkg::word_type     block_ff [shash_pkg::BLOCK_WORDS];
   shash_pkg::block_type    load_block;
   shash_pkg::digest_type   digest;
   shash_pkg::core_ctl_type ctl;
   logic                    core_done;

   logic        accept;
   logic        wr_en;
   logic [5:0]  wr_pos;
   logic [7:0]  wr_byte;
   logic [31:0] wr_word;
   logic        use_len;
   logic [63:0] bit_len;

   assign accept  = req_valid && !req_stall;
   assign bit_len = {count_ff[60:0], 3'b000};
   // The length goes into the block whenever the padding leaves room for it.
   assign use_len = (fill_ff <= 5'(shash_pkg::LEN_HI_WORD));

   // Byte writes keep the earlier bytes of the word and clear the later ones,
   // so a padded block needs no separate clearing.
   always_comb begin
      wr_en   = 1'b0;
      wr_pos  = count_ff[5:0];
      wr_byte = req_data_byte;
      if (state_ff == T_IDLE) begin
         wr_en = accept && req_has_byte;
      end else if (state_ff == T_PAD) begin
         wr_en   = 1'b1;
         wr_byte = shash_pkg::PAD_BYTE;
      end
      for (int l = 0; l < 4; l++) begin
         if (2'(l) < wr_pos[1:0]) begin
            wr_word[31 - 8 * l -: 8] = block_ff[wr_pos[5:2]][31 - 8 * l -: 8];
         end else if (2'(l) == wr_pos[1:0]) begin
            wr_word[31 - 8 * l -: 8] = wr_byte;
         end else begin
            wr_word[31 - 8 * l -: 8] = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_ff[wr_pos[5:2]] <= wr_word;
      end
   end

   // Words past the live fill read as zero; the length lands in the last two.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         load_block[4'(i)] = (5'(i) < fill_ff) ? block_ff[4'(i)] : '0;
      end
      if (use_len) begin
         load_block[shash_pkg::LEN_HI_WORD] = bit_len[63:32];
         load_block[shash_pkg::LEN_LO_WORD] = bit_len[31:0];
      end
   end

   always_comb begin
      ctl.start = (state_ff == T_LAUNCH);
      ctl.init  = (state_ff == T_OUT) && !rsp_stall
                  && (index_ff == shash_pkg::LAST_INDEX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         count_ff <= '0;
         fill_ff  <= '0;
         eom_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         len_ff   <= 1'b0;
         index_ff <= '0;
      end else begin
         case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  eom_ff <= req_end_of_message;
                  if (req_has_byte) begin
                     count_ff <= count_ff + 64'd1;
                  end
                  if (req_has_byte && (count_ff[5:0] == 6'd63)) begin
                     fill_ff  <= 5'(shash_pkg::BLOCK_WORDS);
                     state_ff <= T_LAUNCH;
                  end else if (req_end_of_message) begin
                     state_ff <= T_PAD;
                  end
               end
            end
            T_PAD: begin
               fill_ff  <= {1'b0, count_ff[5:2]} + 5'd1;
               pad_ff   <= 1'b1;
               state_ff <= T_LAUNCH;
            end
            T_LAUNCH: begin
               len_ff   <= use_len;
               state_ff <= T_WAIT;
            end
            T_WAIT: begin
               if (core_done) begin
                  if (len_ff) begin
                     index_ff <= '0;
                     state_ff <= T_OUT;
                  end else if (pad_ff) begin
                     // The padding spilled over; the length goes in a block of its own.
                     fill_ff  <= '0;
                     state_ff <= T_LAUNCH;
                  end else if (eom_ff) begin
                     state_ff <= T_PAD;
                  end else begin
                     state_ff <= T_IDLE;
                  end
               end
            end
            T_OUT: begin
               if (!rsp_stall) begin
                  index_ff <= index_ff + 3'd1;
                  if (index_ff == shash_pkg::LAST_INDEX) begin
                     count_ff <= '0;
                     fill_ff  <= '0;
                     eom_ff   <= 1'b0;
                     pad_ff   <= 1'b0;
                     len_ff   <= 1'b0;
                     state_ff <= T_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   shash_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .block  (load_block),
      .digest (digest),
      .done   (core_done)
   );

   assign req_stall       = (state_ff != T_IDLE);
   assign rsp_valid       = (state_ff == T_OUT);
   assign rsp_digest_word = digest[index_ff];
   assign rsp_word_index  = index_ff;
   assign rsp_last_word   = (index_ff == shash_pkg::LAST_INDEX);

endmodule

### src/shash_core.sv
`timescale 1ns / 1ps
// SHA-256 compression core: one round per cycle, then a chaining add.
module shash_core (
   input  logic                     clock,
   input  logic                     reset,
   input  shash_pkg::core_ctl_type  ctl,
   input  shash_pkg::block_type     block,
   output shash_pkg::digest_type    digest,
   output logic                     done
);

   typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} state_type;

   state_type             state_ff;
   logic [5:0]            round_ff;
   logic                  done_ff;
   shash_pkg::digest_type chain_ff;
   shash_pkg::digest_type work_ff;
   shash_pkg::digest_type work_in;
   shash_pkg::block_type  sched_ff;
   shash_pkg::block_type  sched_in;

   shash_pkg::word_type big0, big1, ch, maj, t1, t2, sig0, sig1, w_new;

   // One round of the compression function; work_ff[0] is a, work_ff[7] is h.
   always_comb begin
      big1 = shash_pkg::rotr(work_ff[4], 6) ^ shash_pkg::rotr(work_ff[4], 11)
           ^ shash_pkg::rotr(work_ff[4], 25);
      ch   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1   = work_ff[7] + big1 + ch + shash_pkg::round_k(round_ff) + sched_ff[0];
      big0 = shash_pkg::rotr(work_ff[0], 2) ^ shash_pkg::rotr(work_ff[0], 13)
           ^ shash_pkg::rotr(work_ff[0], 22);
      maj  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
           ^ (work_ff[1] & work_ff[2]);
      t2   = big0 + maj;
      work_in    = work_ff;
      work_in[7] = work_ff[6];
      work_in[6] = work_ff[5];
      work_in[5] = work_ff[4];
      work_in[4] = work_ff[3] + t1;
      work_in[3] = work_ff[2];
      work_in[2] = work_ff[1];
      work_in[1] = work_ff[0];
      work_in[0] = t1 + t2;
   end

   // The schedule window holds W[r] .. W[r+15]; each round shifts in W[r+16].
   always_comb begin
      sig0  = shash_pkg::rotr(sched_ff[1], 7) ^ shash_pkg::rotr(sched_ff[1], 18)
            ^ (sched_ff[1] >> 3);
      sig1  = shash_pkg::rotr(sched_ff[14], 17) ^ shash_pkg::rotr(sched_ff[14], 19)
            ^ (sched_ff[14] >> 10);
      w_new = sched_ff[0] + sig0 + sched_ff[9] + sig1;
      for (int i = 0; i < 15; i++) begin
         sched_in[4'(i)] = sched_ff[4'(i + 1)];
      end
      sched_in[15] = w_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         round_ff <= '0;
         done_ff  <= 1'b0;
         chain_ff <= shash_pkg::INITIAL_HASH;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            C_IDLE: begin
               if (ctl.init) begin
                  chain_ff <= shash_pkg::INITIAL_HASH;
               end
               if (ctl.start) begin
                  sched_ff <= block;
                  work_ff  <= chain_ff;
                  round_ff <= '0;
                  state_ff <= C_ROUND;
               end
            end
            C_ROUND: begin
               work_ff  <= work_in;
               sched_ff <= sched_in;
               round_ff <= round_ff + 6'd1;
               if (round_ff == shash_pkg::LAST_ROUND) begin
                  state_ff <= C_FINAL;
               end
            end
            C_FINAL: begin
               for (int j = 0; j < 8; j++) begin
                  chain_ff[3'(j)] <= chain_ff[3'(j)] + work_ff[3'(j)];
               end
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: begin
               state_ff <= C_IDLE;
            end
         endcase
      end
   end

   assign digest = chain_ff;
   assign done   = done_ff;

endmodule

### bench/sha256_digest_checker.sv
`timescale 1ns / 1ps
// Checker for the SHA-256 stream hasher: predicts each digest and compares the words.
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          digest_words_pending
);

   typedef shash_pkg::word_type word_type;

   typedef struct {
      word_type    word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   localparam logic [7:0] PADDING_MARK = 8'h80;
   localparam int         FINAL_WORD   = 7;
   localparam int         LENGTH_HIGH  = 14;
   localparam int         LENGTH_LOW   = 15;

   localparam word_type HASH_SEED [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   word_type         chain_state [8];
   word_type         block_buf [16];
   logic [63:0]      byte_total;
   digest_entry_type digest_words_due [$];
   digest_entry_type oldest;

   function automatic word_type ror(input word_type v, input int unsigned s);
      logic [63:0] twice;
      twice = {v, v} >> s;
      return twice[31:0];
   endfunction

   task automatic restart_message();
      chain_state = HASH_SEED;
      foreach (block_buf[j]) block_buf[j] = '0;
      byte_total = '0;
   endtask

   task automatic compress_block();
      word_type sched [16];
      word_type v [8];
      word_type wr, x15, x2, t1, t2;
      sched = block_buf;
      v = chain_state;
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            wr = sched[r];
         end else begin
            x15 = sched[(r - 15) & 15];
            x2 = sched[(r - 2) & 15];
            wr = sched[r & 15] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3))
                 + sched[(r - 7) & 15] + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
            sched[r & 15] = wr;
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain_state[j] = chain_state[j] + v[j];
      foreach (block_buf[j]) block_buf[j] = '0;
   endtask

   task automatic place_byte(input logic [7:0] b);
      logic [5:0] pos;
      int         lane;
      pos = byte_total[5:0];
      lane = 3 - int'(pos[1:0]);
      block_buf[pos[5:2]][8 * lane +: 8] = b;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      place_byte(b);
      byte_total = byte_total + 64'd1;
      if (byte_total[5:0] == 6'd0) compress_block();
   endtask

   // Pads the open block, spilling into a second block when the length field
   // no longer fits, and queues the eight digest words.
   task automatic close_message();
      logic [63:0]      bit_length;
      digest_entry_type entry;
      place_byte(PADDING_MARK);
      if (byte_total[5:0] >= 6'd56) compress_block();
      bit_length = byte_total << 3;
      block_buf[LENGTH_HIGH] = bit_length[63:32];
      block_buf[LENGTH_LOW] = bit_length[31:0];
      compress_block();
      for (int k = 0; k < 8; k++) begin
         entry.word = chain_state[k];
         entry.index = 3'(k);
         entry.last = (k == FINAL_WORD);
         digest_words_due.insert(digest_words_due.size(), entry);
      end
      restart_message();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         digest_words_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_has_byte) absorb_byte(req_data_byte);
            if (req_end_of_message) close_message();
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_words_due.size() == 0) begin
               $error("digest word %h (index %0d) arrived with none expected",
                      rsp_digest_word, rsp_word_index);
               fail_count++;
            end else begin
               oldest = digest_words_due.pop_front();
               if (rsp_digest_word !== oldest.word) begin
                  $error("digest_word: expected %h, got %h", oldest.word, rsp_digest_word);
                  fail_count++;
               end
               if (rsp_word_index !== oldest.index) begin
                  $error("word_index: expected %0d, got %0d", oldest.index, rsp_word_index);
                  fail_count++;
               end
               if (rsp_last_word !== oldest.last) begin
                  $error("last_word: expected %b, got %b", oldest.last, rsp_last_word);
                  fail_count++;
               end
            end
         end
      end
      digest_words_pending = digest_words_due.size();
   end

endmodule

### bench/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps
// Testbench top for the SHA-256 stream hasher: clock, reset, stimulus and verdict.
module tb_sha256_stream_hasher;

   localparam int CLOCK_PERIOD    = 8;
   // The sender stops starting new random messages once this many message
   // transactions have gone in and enough digests have been requested.
   localparam int RANDOM_ITEMS    = 180;
   localparam int MIN_MESSAGES    = 6;
   localparam int QUIET_MESSAGES  = 2;
   // Long enough that the sender sits stalled behind an unread digest for a
   // good while.
   localparam int HOLD_OFF_CYCLES = 300;
   // Two block compressions plus the digest words cover any late stray output.
   localparam int DRAIN_CYCLES    = 160;
   localparam int RUN_LIMIT_NS    = 1_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   int fail_count;
   int digest_words_pending;

   // Shared between the two sides: when clear, neither side inserts random gaps; the long hold-off still runs.
   bit gaps_enabled = 1'b1;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_off_req = 1'b0;
   bit hold_off_done = 1'b0;

   int message_items;
   int messages_sent;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   sha256_stream_hasher i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   sha256_digest_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_has_byte         (req_has_byte),
      .req_end_of_message   (req_end_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_digest_word      (rsp_digest_word),
      .rsp_word_index       (rsp_word_index),
      .rsp_last_word        (rsp_last_word),
      .fail_count           (fail_count),
      .digest_words_pending (digest_words_pending)
   );

   // Presents one transaction and returns at the edge that accepts it. An
   // optional idle burst goes in front, so gaps land wherever the message is.
   // Valid is only ever raised here, and lowered only ahead of a burst or after
   // the last message, so it never gets two assignments in one time step.
   task automatic offer_item(input logic [7:0] b, input logic has, input logic eom);
      if (gaps_enabled && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_has_byte <= has;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_stall);
   endtask

   // Sends a message of the given length with random content. The mark rides
   // on the final byte half the time, otherwise it follows as a bare mark.
   // Now and then a transaction with neither byte nor mark is slipped in; the
   // block must ignore it, so it does not count as a message transaction.
   task automatic send_message(input int len);
      bit close_on_byte;
      close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) offer_item(8'($urandom), 1'b0, 1'b0);
         offer_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
         message_items++;
      end
      if (!close_on_byte) begin
         offer_item(8'($urandom), 1'b0, 1'b1);
         message_items++;
      end
      messages_sent++;
   endtask

   // Mostly short messages, so that digests come often, with a share of
   // lengths around the block and padding boundaries: 55 bytes still fits the
   // length field, 56 to 63 spill into an extra block, 64 fills a block
   // exactly, and 119 or 120 repeat the 55/56 boundary after one full block.
   function automatic int pick_length();
      int edge_lengths [10] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 127};
      if ($urandom_range(0, 3) == 0) return edge_lengths[$urandom_range(0, 9)];
      return $urandom_range(0, 20);
   endfunction

   // Receiver side. Random stall bursts while gaps are allowed, and one long
   // hold-off on request, started once a digest is waiting, so that the block
   // has to stall its input while the sender keeps offering.
   initial begin : digest_receiver
      @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done && rsp_valid) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_done = 1'b1;
            @(posedge clock);
         end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   initial begin : message_source
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty message, by a lone mark.
      offer_item(8'hff, 1'b0, 1'b1);
      // "abc" closed by a bare mark, with an ignored transaction before it
      // and another in the middle of the message.
      offer_item(8'h00, 1'b0, 1'b0);
      offer_item(8'h61, 1'b1, 1'b0);
      offer_item(8'hff, 1'b0, 1'b0);
      offer_item(8'h62, 1'b1, 1'b0);
      offer_item(8'h63, 1'b1, 1'b0);
      offer_item(8'h5a, 1'b0, 1'b1);
      // One-byte messages at both byte extremes, the mark on the byte.
      offer_item(8'hff, 1'b1, 1'b1);
      offer_item(8'h00, 1'b1, 1'b1);
      // Alternating extremes, mark on the last byte.
      for (int i = 0; i < 8; i++) offer_item((i % 2 == 0) ? 8'h00 : 8'hff, 1'b1, i == 7);
      // The empty message again, right behind another one.
      offer_item(8'h00, 1'b0, 1'b1);

      // Random part. It opens with the long hold-off on the receiver.
      message_items = 0;
      messages_sent = 0;
      hold_off_req = 1'b1;
      while (message_items < RANDOM_ITEMS || messages_sent < MIN_MESSAGES) begin
         gaps_enabled = ($urandom_range(0, 3) != 0);
         send_message(pick_length());
      end

      // The final stretch runs at full rate on both sides.
      gaps_enabled = 1'b0;
      repeat (QUIET_MESSAGES) send_message(pick_length());
      req_valid <= 1'b0;

      // Let the checker see the last accepted transaction before asking it.
      @(posedge clock);
      wait (digest_words_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
src/shash_pkg.sv
src/shash_core.sv
src/sha256_stream_hasher.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_stream_hasher.sv
